// File: rtl/htm_pkg.sv
package htm_pkg;

   localparam int LEVEL_W = 16;
   localparam int T_W     = 25;
   localparam int Y24_W   = 25;

   localparam logic [LEVEL_W-1:0] ONE_Q14    = 16'd16384;
   localparam logic [LEVEL_W-1:0] RESET_HEAD = 16'd32768;
   localparam logic [LEVEL_W-1:0] RESET_MAXL = 16'd32768;

   localparam logic CSR_HEADROOM = 1'b0;
   localparam logic CSR_MAX_LUM  = 1'b1;

   // floor(x/3) for x < 2^22, and floor(x/625) for x < 2^34
   localparam logic [22:0] RECIP3   = 23'd5592406;
   localparam logic [34:0] RECIP625 = 35'd28147497672;
   // 5000 * 2^16, the rounding half of 10000 * 2^16
   localparam logic [63:0] Y_HALF   = 64'd327680000;

   localparam int DIV_STAGES = 8;

   typedef struct packed {
      logic                valid;
      logic                bypass;
      logic [LEVEL_W-1:0]  level;
   } tag_type;

   typedef struct packed {
      tag_type             tag;
      logic [2:0]          seg;
      logic [T_W-1:0]      t;
   } param_type;

   typedef struct packed {
      tag_type             tag;
      logic [Y24_W-1:0]    y24;
   } curve_type;

   typedef struct packed {
      tag_type             tag;
      logic                neg;
      logic                big;
      logic [31:0]         dividend;
      logic [15:0]         divisor;
   } blend_type;

   typedef struct packed {
      tag_type             tag;
      logic                neg;
      logic                big;
      logic [15:0]         quot;
   } quot_type;

   function automatic logic [13:0] seg_y0(input logic [2:0] seg);
      logic [13:0] r;
      unique case (seg)
         3'd0: r = 14'd0;
         3'd1: r = 14'd7500;
         3'd2: r = 14'd9500;
         3'd3: r = 14'd9700;
         3'd4: r = 14'd9800;
         3'd5: r = 14'd9875;
         3'd6: r = 14'd9950;
         default: r = 14'd0;
      endcase
      return r;
   endfunction

   function automatic logic [12:0] seg_lin(input logic [2:0] seg);
      logic [12:0] r;
      unique case (seg)
         3'd0: r = 13'd7500;
         3'd1: r = 13'd2500;
         3'd2: r = 13'd250;
         3'd3: r = 13'd50;
         3'd4: r = 13'd0;
         3'd5: r = 13'd50;
         3'd6: r = 13'd60;
         default: r = 13'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [10:0] seg_quad(input logic [2:0] seg);
      logic signed [10:0] r;
      unique case (seg)
         3'd0: r = 11'sd0;
         3'd1: r = -11'sd500;
         3'd2: r = -11'sd50;
         3'd3: r = 11'sd50;
         3'd4: r = 11'sd75;
         3'd5: r = 11'sd25;
         3'd6: r = -11'sd10;
         default: r = 11'sd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/htm_param.sv
module htm_param (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  htm_pkg::tag_type    in_tag,
   output htm_pkg::param_type  out_p
);
   import htm_pkg::*;

   typedef struct packed {
      tag_type         tag;
      logic [2:0]      seg;
      logic [T_W-1:0]  v;
      logic            div3;
   } s1_type;

   s1_type     s1_ff, s1_in;
   param_type  s2_ff, s2_in;
   logic [15:0] lvl;
   logic [25:0] hi_v;
   logic [44:0] prod;

   assign lvl  = in_tag.level;
   assign hi_v = 26'(lvl) * 26'd640 - 26'd19922944;

   always_comb begin
      s1_in.tag = in_tag;
      priority if (lvl <= 16'd12288) begin
         s1_in.seg  = 3'd0;
         s1_in.v    = T_W'({lvl, 8'b0}) + T_W'(1);
         s1_in.div3 = 1'b1;
      end else if (lvl <= 16'd16384) begin
         s1_in.seg  = 3'd1;
         s1_in.v    = T_W'({16'(lvl - 16'd12288), 8'b0});
         s1_in.div3 = 1'b0;
      end else if (lvl <= 16'd20480) begin
         s1_in.seg  = 3'd2;
         s1_in.v    = T_W'({16'(lvl - 16'd16384), 8'b0});
         s1_in.div3 = 1'b0;
      end else if (lvl <= 16'd24576) begin
         s1_in.seg  = 3'd3;
         s1_in.v    = T_W'({16'(lvl - 16'd20480), 8'b0});
         s1_in.div3 = 1'b0;
      end else if (lvl <= 16'd28672) begin
         s1_in.seg  = 3'd4;
         s1_in.v    = T_W'({16'(lvl - 16'd24576), 8'b0});
         s1_in.div3 = 1'b0;
      end else if (lvl <= 16'd31129) begin
         s1_in.seg  = 3'd5;
         s1_in.v    = T_W'(12'(lvl - 16'd28672)) * T_W'(1280) + T_W'(1);
         s1_in.div3 = 1'b1;
      end else begin
         s1_in.seg  = 3'd6;
         s1_in.v    = hi_v[T_W-1:0];
         s1_in.div3 = 1'b0;
      end
   end

   // rounded third: floor(v / 3), with the + 1 already added into v
   assign prod = 45'(s1_ff.v[21:0]) * 45'(RECIP3);

   always_comb begin
      s2_in.tag = s1_ff.tag;
      s2_in.seg = s1_ff.seg;
      s2_in.t   = s1_ff.div3 ? T_W'(prod >> 24) : s1_ff.v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.tag.valid <= 1'b0;
         s2_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign out_p = s2_ff;

endmodule

// File: rtl/htm_curve.sv
module htm_curve (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  htm_pkg::param_type  in_p,
   output htm_pkg::curve_type  out_c
);
   import htm_pkg::*;

   typedef struct packed {
      tag_type               tag;
      logic [2:0]            seg;
      logic [T_W-1:0]        t;
      logic [37:0]           lt;
      logic signed [35:0]    qt;
   } s3_type;

   typedef struct packed {
      tag_type               tag;
      logic [2:0]            seg;
      logic [37:0]           lt;
      logic signed [60:0]    qtt;
   } s4_type;

   typedef struct packed {
      tag_type               tag;
      logic [33:0]           xq;
   } s5_type;

   typedef struct packed {
      tag_type               tag;
      logic [51:0]           plo;
      logic [51:0]           phi;
   } s6_type;

   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   curve_type s7_ff, s7_in;

   logic signed [10:0] quad;
   logic signed [63:0] yfix;
   logic signed [63:0] yrnd;
   logic [69:0]        psum;

   assign quad = seg_quad(in_p.seg);

   always_comb begin
      s3_in.tag = in_p.tag;
      s3_in.seg = in_p.seg;
      s3_in.t   = in_p.t;
      s3_in.lt  = 38'(seg_lin(in_p.seg)) * 38'(in_p.t);
      s3_in.qt  = $signed({{25{quad[10]}}, quad}) * $signed({11'b0, in_p.t});
   end

   always_comb begin
      s4_in.tag = s3_ff.tag;
      s4_in.seg = s3_ff.seg;
      s4_in.lt  = s3_ff.lt;
      s4_in.qtt = $signed({{25{s3_ff.qt[35]}}, s3_ff.qt}) * $signed({36'b0, s3_ff.t});
   end

   // y in units of 2^-40 of the 1/10000 scale, then rounded to nearest 2^-24
   assign yfix = $signed({10'b0, seg_y0(s4_ff.seg), 40'b0})
               + $signed({6'b0, s4_ff.lt, 20'b0})
               + $signed({{3{s4_ff.qtt[60]}}, s4_ff.qtt});
   assign yrnd = yfix + $signed(Y_HALF);

   always_comb begin
      s5_in.tag = s4_ff.tag;
      s5_in.xq  = yrnd[53:20];
   end

   always_comb begin
      s6_in.tag = s5_ff.tag;
      s6_in.plo = 52'(RECIP625) * 52'(s5_ff.xq[16:0]);
      s6_in.phi = 52'(RECIP625) * 52'(s5_ff.xq[33:17]);
   end

   assign psum = {1'b0, s6_ff.phi, 17'b0} + 70'(s6_ff.plo);

   always_comb begin
      s7_in.tag = s6_ff.tag;
      s7_in.y24 = psum[68:44];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.tag.valid <= 1'b0;
         s4_ff.tag.valid <= 1'b0;
         s5_ff.tag.valid <= 1'b0;
         s6_ff.tag.valid <= 1'b0;
         s7_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   assign out_c = s7_ff;

endmodule

// File: rtl/htm_blend.sv
module htm_blend (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [15:0]         headroom,
   input  logic [15:0]         max_lum,
   input  htm_pkg::curve_type  in_c,
   output htm_pkg::blend_type  out_b
);
   import htm_pkg::*;

   typedef struct packed {
      tag_type               tag;
      logic [Y24_W-1:0]      y24;
      logic [41:0]           wy;
      logic signed [33:0]    hl;
   } s8_type;

   typedef struct packed {
      tag_type               tag;
      logic signed [37:0]    quo_a;
      logic [15:0]           divisor;
   } s9_type;

   s8_type    s8_ff, s8_in;
   s9_type    s9_ff, s9_in;
   blend_type s10_ff, s10_in;

   logic [16:0]        mh;
   logic signed [16:0] hs;
   logic [15:0]        dm;
   logic signed [47:0] num;
   logic [25:0]        yr;

   assign mh = 17'(max_lum) - 17'(headroom);
   assign hs = $signed(17'(headroom) - 17'(ONE_Q14));
   assign dm = max_lum - ONE_Q14;

   always_comb begin
      s8_in.tag = in_c.tag;
      s8_in.y24 = in_c.y24;
      s8_in.wy  = 42'(mh) * 42'(in_c.y24);
      s8_in.hl  = $signed({{17{hs[16]}}, hs}) * $signed({18'b0, in_c.tag.level});
   end

   assign num = $signed({6'b0, s8_ff.wy})
              + $signed({{4{s8_ff.hl[33]}}, s8_ff.hl, 10'b0})
              + $signed({23'b0, dm, 9'b0});
   assign yr  = 26'(s8_ff.y24) + 26'd512;

   always_comb begin
      s9_in.tag = s8_ff.tag;
      if (max_lum > ONE_Q14) begin
         s9_in.quo_a   = num[47:10];
         s9_in.divisor = dm;
      end else begin
         s9_in.quo_a   = $signed(38'(yr[25:10]));
         s9_in.divisor = 16'd1;
      end
   end

   always_comb begin
      s10_in.tag      = s9_ff.tag;
      s10_in.neg      = s9_ff.quo_a[37];
      s10_in.big      = !s9_ff.quo_a[37]
                     && (s9_ff.quo_a[36:0] >= 37'({s9_ff.divisor, 16'b0}));
      s10_in.dividend = s9_ff.quo_a[31:0];
      s10_in.divisor  = s9_ff.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ff.tag.valid  <= 1'b0;
         s9_ff.tag.valid  <= 1'b0;
         s10_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
      end
   end

   assign out_b = s10_ff;

endmodule

// File: rtl/htm_div.sv
module htm_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  htm_pkg::blend_type  in_b,
   output htm_pkg::quot_type   out_q
);
   import htm_pkg::*;

   typedef struct packed {
      tag_type       tag;
      logic          neg;
      logic          big;
      logic [15:0]   rem;
      logic [15:0]   low;
      logic [15:0]   quot;
      logic [15:0]   divisor;
   } dstage_type;

   dstage_type st_ff [DIV_STAGES];
   dstage_type st_in [DIV_STAGES];
   dstage_type head;

   // one restoring step: shift in a dividend bit, subtract when it fits
   function automatic dstage_type div_step(input dstage_type s);
      dstage_type r;
      logic [16:0] r2;
      r  = s;
      r2 = {s.rem, s.low[15]};
      if (r2 >= {1'b0, s.divisor}) begin
         r.rem  = 16'(r2 - {1'b0, s.divisor});
         r.quot = {s.quot[14:0], 1'b1};
      end else begin
         r.rem  = r2[15:0];
         r.quot = {s.quot[14:0], 1'b0};
      end
      r.low = {s.low[14:0], 1'b0};
      return r;
   endfunction

   always_comb begin
      head.tag     = in_b.tag;
      head.neg     = in_b.neg;
      head.big     = in_b.big;
      head.rem     = in_b.dividend[31:16];
      head.low     = in_b.dividend[15:0];
      head.quot    = 16'd0;
      head.divisor = in_b.divisor;
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign st_in[g] = div_step(div_step(head));
      end else begin : g_rest
         assign st_in[g] = div_step(div_step(st_ff[g-1]));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g].tag.valid <= 1'b0;
         end else if (adv) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   always_comb begin
      out_q.tag  = st_ff[DIV_STAGES-1].tag;
      out_q.neg  = st_ff[DIV_STAGES-1].neg;
      out_q.big  = st_ff[DIV_STAGES-1].big;
      out_q.quot = st_ff[DIV_STAGES-1].quot;
   end

endmodule

// File: rtl/hdr_bezier_tone_map_unit.sv
// HDR tone map: one UQ2.14 colour level per word in, one mapped level out.
// Request channel req_valid/req_ready carries req_level; response channel
// rsp_valid/rsp_ready carries rsp_mapped_level and rsp_curve_fallback.
// Configuration: csr_we with csr_index 0 writes the display headroom,
// index 1 the maximum luminance; both reset to 2.0. Write only when idle.
// Pipeline: a word passes 19 registers (2 curve parameter, 5 curve value,
// 3 blend, 8 divider at two quotient bits each, 1 output register), the
// last of which drives rsp_valid. Throughput: one word per cycle while
// responses are taken; the whole pipeline advances together whenever the
// output register is empty or being taken.
// When the receiver stalls, the pipeline holds; a word arriving in that
// cycle is parked in an input skid register and req_ready drops until
// the pipeline moves again. Nothing is lost or repeated.
// Reset (synchronous, active high) empties every stage and the skid
// register and restores both configuration registers.
module hdr_bezier_tone_map_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [15:0]  req_level,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [15:0]  rsp_mapped_level,
   output logic         rsp_curve_fallback,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import htm_pkg::*;

   logic [15:0] head_ff, maxl_ff;
   logic        skid_v_ff, skid_v_in;
   logic [15:0] skid_level_ff;
   logic        out_v_ff;
   logic [15:0] out_level_ff, out_level_in;
   logic        adv;

   tag_type    front;
   param_type  p_w;
   curve_type  c_w;
   blend_type  b_w;
   quot_type   q_w;

   assign adv       = !out_v_ff || rsp_ready;
   assign req_ready = !skid_v_ff;
   assign skid_v_in = adv ? 1'b0 : (skid_v_ff || req_valid);

   always_comb begin
      front.valid  = skid_v_ff || req_valid;
      front.bypass = head_ff >= maxl_ff;
      front.level  = skid_v_ff ? skid_level_ff : req_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= RESET_HEAD;
         maxl_ff <= RESET_MAXL;
      end else if (csr_we) begin
         unique case (csr_index[0])
            CSR_HEADROOM: head_ff <= csr_wdata;
            CSR_MAX_LUM:  maxl_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
      if (!skid_v_ff) begin
         skid_level_ff <= req_level;
      end
   end

   htm_param u_param (
      .clock (clock), .reset (reset), .adv (adv), .in_tag (front), .out_p (p_w)
   );

   htm_curve u_curve (
      .clock (clock), .reset (reset), .adv (adv), .in_p (p_w), .out_c (c_w)
   );

   htm_blend u_blend (
      .clock (clock), .reset (reset), .adv (adv),
      .headroom (head_ff), .max_lum (maxl_ff), .in_c (c_w), .out_b (b_w)
   );

   htm_div u_div (
      .clock (clock), .reset (reset), .adv (adv), .in_b (b_w), .out_q (q_w)
   );

   always_comb begin
      priority if (q_w.tag.bypass) begin
         out_level_in = q_w.tag.level;
      end else if (q_w.neg) begin
         out_level_in = 16'd0;
      end else if (q_w.big || (q_w.quot > head_ff)) begin
         out_level_in = head_ff;
      end else begin
         out_level_in = q_w.quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= q_w.tag.valid;
      end
      if (adv) begin
         out_level_ff <= out_level_in;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_mapped_level   = out_level_ff;
   assign rsp_curve_fallback = 1'b0;

endmodule

// File: rtl/htm_checker.sv
module htm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [15:0]  rsp_mapped_level,
   input logic         rsp_curve_fallback
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mapped_level))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_no_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_curve_fallback)
      else $error("curve fallback raised");

endmodule

bind hdr_bezier_tone_map_unit htm_checker u_htm_checker (.*);
